// File: rtl/mqlf_pkg.sv
package mqlf_pkg;

    localparam int NUM_QUEUES = 3;
    localparam int POOL_DEPTH = 256;

    localparam int QIDX_W = 2;
    localparam int DATA_W = 16;
    localparam int STAT_W = 2;
    localparam int PTR_W  = $clog2(POOL_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int REC_W  = 2 * DATA_W;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    localparam logic [STAT_W-1:0] STAT_APPENDED = 2'd0;
    localparam logic [STAT_W-1:0] STAT_REMOVED  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd3;

    typedef struct packed {
        logic              mode;
        logic              reject;
        logic [QSEL_W-1:0] q_sel;
        logic [DATA_W-1:0] cls;
        logic [DATA_W-1:0] grd;
    } cmd_t;

endpackage

// File: rtl/mqlf_ram.sv
module mqlf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/mqlf_front.sv
module mqlf_front
    import mqlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [QIDX_W-1:0] s_queue_index,
    input  logic [DATA_W-1:0] s_item_class,
    input  logic [DATA_W-1:0] s_item_grade,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output cmd_t              cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    cmd_t       in_cmd;
    logic       push;
    logic       pop;

    always_comb begin
        in_cmd.mode   = s_mode;
        in_cmd.reject = (32'(s_queue_index) >= 32'(NUM_QUEUES));
        in_cmd.q_sel  = QSEL_W'(s_queue_index);
        in_cmd.cls    = s_item_class;
        in_cmd.grd    = s_item_grade;
    end

    assign s_ready   = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/mqlf_back.sv
module mqlf_back
    import mqlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [DATA_W-1:0] m_out_class,
    output logic [DATA_W-1:0] m_out_grade
);

    typedef enum logic {ST_IDLE, ST_EXEC} state_t;

    state_t            state_reg, state_next;
    logic [PTR_W-1:0]  head_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  head_next [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_reg [NUM_QUEUES];
    logic [PTR_W-1:0]  tail_next [NUM_QUEUES];
    logic [NUM_QUEUES-1:0] nonempty_reg, nonempty_next;
    logic [CNT_W-1:0]  fc_reg, fc_next;
    logic [CNT_W-1:0]  lw_reg, lw_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [DATA_W-1:0] out_class_reg, out_class_next;
    logic [DATA_W-1:0] out_grade_reg, out_grade_next;
    logic              mode_reg, mode_next;
    logic [QSEL_W-1:0] q_reg, q_next;
    logic [PTR_W-1:0]  idx_reg, idx_next;
    logic              use_init_reg, use_init_next;
    logic [DATA_W-1:0] cls_reg, cls_next;
    logic [DATA_W-1:0] grd_reg, grd_next;

    logic              rs_we, rs_re;
    logic [PTR_W-1:0]  rs_waddr, rs_raddr;
    logic [REC_W-1:0]  rs_rdata;
    logic              nl_we, nl_re;
    logic [PTR_W-1:0]  nl_waddr, nl_raddr, nl_wdata, nl_rdata;
    logic              fs_we, fs_re;
    logic [PTR_W-1:0]  fs_waddr, fs_raddr, fs_wdata, fs_rdata;

    logic              out_free;
    logic [CNT_W-1:0]  fc_dec;
    logic [PTR_W-1:0]  pop_pos;
    logic [PTR_W-1:0]  new_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign fc_dec   = fc_reg - CNT_W'(1);
    assign pop_pos  = fc_dec[PTR_W-1:0];
    assign new_idx  = use_init_reg ? idx_reg : fs_rdata;

    mqlf_ram #(.WIDTH(REC_W), .DEPTH(POOL_DEPTH)) u_record_store (
        .aclk  (aclk),
        .we    (rs_we),
        .waddr (rs_waddr),
        .wdata ({cls_reg, grd_reg}),
        .re    (rs_re),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    mqlf_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_next_link (
        .aclk  (aclk),
        .we    (nl_we),
        .waddr (nl_waddr),
        .wdata (nl_wdata),
        .re    (nl_re),
        .raddr (nl_raddr),
        .rdata (nl_rdata)
    );

    mqlf_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_free_stack (
        .aclk  (aclk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .re    (fs_re),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        nonempty_next  = nonempty_reg;
        fc_next        = fc_reg;
        lw_next        = lw_reg;
        m_valid_next   = m_valid_reg;
        status_next    = status_reg;
        out_class_next = out_class_reg;
        out_grade_next = out_grade_reg;
        mode_next      = mode_reg;
        q_next         = q_reg;
        idx_next       = idx_reg;
        use_init_next  = use_init_reg;
        cls_next       = cls_reg;
        grd_next       = grd_reg;
        cmd_ready      = 1'b0;
        rs_we          = 1'b0;
        rs_re          = 1'b0;
        rs_waddr       = new_idx;
        rs_raddr       = head_reg[cmd.q_sel];
        nl_we          = 1'b0;
        nl_re          = 1'b0;
        nl_waddr       = tail_reg[q_reg];
        nl_wdata       = new_idx;
        nl_raddr       = head_reg[cmd.q_sel];
        fs_we          = 1'b0;
        fs_re          = 1'b0;
        fs_waddr       = fc_reg[PTR_W-1:0];
        fs_wdata       = idx_reg;
        fs_raddr       = pop_pos;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid && out_free) begin
                    cmd_ready = 1'b1;
                    mode_next = cmd.mode;
                    q_next    = cmd.q_sel;
                    cls_next  = cmd.cls;
                    grd_next  = cmd.grd;
                    if (cmd.mode == MODE_APPEND) begin
                        if (cmd.reject || fc_reg == '0) begin
                            m_valid_next   = 1'b1;
                            status_next    = STAT_FULL;
                            out_class_next = '0;
                            out_grade_next = '0;
                        end else begin
                            fs_re         = 1'b1;
                            idx_next      = pop_pos;
                            use_init_next = (fc_dec < lw_reg);
                            state_next    = ST_EXEC;
                        end
                    end else begin
                        if (cmd.reject || !nonempty_reg[cmd.q_sel]) begin
                            m_valid_next   = 1'b1;
                            status_next    = STAT_EMPTY;
                            out_class_next = '0;
                            out_grade_next = '0;
                        end else begin
                            rs_re      = 1'b1;
                            nl_re      = 1'b1;
                            idx_next   = head_reg[cmd.q_sel];
                            state_next = ST_EXEC;
                        end
                    end
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                    if (mode_reg == MODE_APPEND) begin
                        rs_we = 1'b1;
                        if (nonempty_reg[q_reg]) begin
                            nl_we = 1'b1;
                        end else begin
                            head_next[q_reg]     = new_idx;
                            nonempty_next[q_reg] = 1'b1;
                        end
                        tail_next[q_reg] = new_idx;
                        fc_next          = fc_dec;
                        if (use_init_reg) begin
                            lw_next = fc_dec;
                        end
                        status_next    = STAT_APPENDED;
                        out_class_next = '0;
                        out_grade_next = '0;
                    end else begin
                        if (idx_reg == tail_reg[q_reg]) begin
                            nonempty_next[q_reg] = 1'b0;
                        end else begin
                            head_next[q_reg] = nl_rdata;
                        end
                        if (fc_reg < CNT_W'(POOL_DEPTH)) begin
                            fs_we   = 1'b1;
                            fc_next = fc_reg + CNT_W'(1);
                        end
                        status_next    = STAT_REMOVED;
                        out_class_next = rs_rdata[REC_W-1:DATA_W];
                        out_grade_next = rs_rdata[DATA_W-1:0];
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        status_reg    <= status_next;
        out_class_reg <= out_class_next;
        out_grade_reg <= out_grade_next;
        mode_reg      <= mode_next;
        q_reg         <= q_next;
        idx_reg       <= idx_next;
        use_init_reg  <= use_init_next;
        cls_reg       <= cls_next;
        grd_reg       <= grd_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            nonempty_reg <= '0;
            fc_reg       <= CNT_W'(POOL_DEPTH);
            lw_reg       <= CNT_W'(POOL_DEPTH);
            for (int i = 0; i < NUM_QUEUES; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            m_valid_reg  <= m_valid_next;
            nonempty_reg <= nonempty_next;
            fc_reg       <= fc_next;
            lw_reg       <= lw_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_out_class = out_class_reg;
    assign m_out_grade = out_grade_reg;

endmodule

// File: rtl/multi_queue_linked_fifo_core.sv
// Channel   Dir   Ports
// input     in    s_valid, s_ready, s_mode, s_queue_index, s_item_class, s_item_grade
// result    out   m_valid, m_ready, m_status, m_out_class, m_out_grade
//
// Append or remove that touches the pool: ST_IDLE reads the pool RAMs, ST_EXEC writes back.
// Refused append or removal from an empty queue: answered from ST_IDLE without ST_EXEC.
// A two-entry command queue takes transactions while the back unit works.
// Reset needs no clearing pass: a low-water mark supplies the free stack's initial indices.
// The back unit holds while a result waits on m_ready.
module multi_queue_linked_fifo_core
    import mqlf_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_mode,
    input  logic [QIDX_W-1:0] s_queue_index,
    input  logic [DATA_W-1:0] s_item_class,
    input  logic [DATA_W-1:0] s_item_grade,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [DATA_W-1:0] m_out_class,
    output logic [DATA_W-1:0] m_out_grade
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    mqlf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_queue_index (s_queue_index),
        .s_item_class  (s_item_class),
        .s_item_grade  (s_item_grade),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd)
    );

    mqlf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_out_class (m_out_class),
        .m_out_grade (m_out_grade)
    );

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import mqlf_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_OPS  = 500;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE      = 20;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] cls;
        logic [DATA_W-1:0] grd;
    } queue_reply_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              s_valid       = 1'b0;
    logic              s_mode        = MODE_APPEND;
    logic [QIDX_W-1:0] s_queue_index = '0;
    logic [DATA_W-1:0] s_item_class  = '0;
    logic [DATA_W-1:0] s_item_grade  = '0;
    logic              m_ready       = 1'b0;
    logic              s_ready;
    logic              m_valid;
    logic [STAT_W-1:0] m_status;
    logic [DATA_W-1:0] m_out_class;
    logic [DATA_W-1:0] m_out_grade;

    // shadow of the linked queues
    logic [PTR_W-1:0] q_head   [NUM_QUEUES];
    logic [PTR_W-1:0] q_tail   [NUM_QUEUES];
    logic             q_live   [NUM_QUEUES];
    logic [PTR_W-1:0] link_of  [POOL_DEPTH];
    logic [REC_W-1:0] rec_of   [POOL_DEPTH];
    logic [PTR_W-1:0] free_idx [POOL_DEPTH];
    int unsigned      free_cnt;

    queue_reply_t replies_due[$];
    int unsigned  err_count   = 0;
    int unsigned  cycle_count = 0;
    bit           calm        = 1'b0;
    int           sink_hold   = 0;

    multi_queue_linked_fifo_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_queue_index (s_queue_index),
        .s_item_class  (s_item_class),
        .s_item_grade  (s_item_grade),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_out_class   (m_out_class),
        .m_out_grade   (m_out_grade)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic clear_shadow();
        for (int k = 0; k < NUM_QUEUES; k++) begin
            q_head[k] = '0;
            q_tail[k] = '0;
            q_live[k] = 1'b0;
        end
        for (int k = 0; k < POOL_DEPTH; k++) begin
            free_idx[k] = PTR_W'(k);
        end
        free_cnt = POOL_DEPTH;
    endtask

    function automatic queue_reply_t apply_queue_op(logic mode, logic [QIDX_W-1:0] qi,
                                                    logic [DATA_W-1:0] cls,
                                                    logic [DATA_W-1:0] grd);
        queue_reply_t r;
        logic [PTR_W-1:0] slot;
        r = '0;
        if (mode == MODE_APPEND) begin
            if (qi >= NUM_QUEUES || free_cnt == 0) begin
                r.status = STAT_FULL;
            end else begin
                free_cnt--;
                slot = free_idx[free_cnt];
                rec_of[slot] = {cls, grd};
                if (q_live[qi]) begin
                    link_of[q_tail[qi]] = slot;
                end else begin
                    q_head[qi] = slot;
                    q_live[qi] = 1'b1;
                end
                q_tail[qi] = slot;
                r.status = STAT_APPENDED;
            end
        end else if (qi >= NUM_QUEUES || !q_live[qi]) begin
            r.status = STAT_EMPTY;
        end else begin
            slot = q_head[qi];
            {r.cls, r.grd} = rec_of[slot];
            if (slot == q_tail[qi]) begin
                q_live[qi] = 1'b0;
            end else begin
                q_head[qi] = link_of[slot];
            end
            free_idx[free_cnt] = slot;
            free_cnt++;
            r.status = STAT_REMOVED;
        end
        return r;
    endfunction

    task automatic send_op(logic mode, logic [QIDX_W-1:0] qi,
                           logic [DATA_W-1:0] cls, logic [DATA_W-1:0] grd);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_mode        <= mode;
        s_queue_index <= qi;
        s_item_class  <= cls;
        s_item_grade  <= grd;
        do @(posedge aclk); while (!s_ready);
        replies_due.push_back(apply_queue_op(mode, qi, cls, grd));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (replies_due.size() != 0);
    endtask

    // result side
    initial begin : result_sink
        int stall;
        queue_reply_t want;
        @(posedge aclk iff aresetn);
        forever begin
            if (sink_hold > 0) begin
                stall = sink_hold;
                sink_hold = 0;
            end else begin
                stall = calm ? 0 : $urandom_range(0, 6);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (replies_due.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected transaction: status %0d class %h grade %h",
                             m_status, m_out_class, m_out_grade);
            end else begin
                want = replies_due.pop_front();
                if (m_status !== want.status || m_out_class !== want.cls ||
                    m_out_grade !== want.grd) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("mismatch: status %0d/%0d class %h/%h grade %h/%h (exp/act)",
                                 want.status, m_status, want.cls, m_out_class,
                                 want.grd, m_out_grade);
                end
            end
        end
    end

    task automatic test_empty_and_range();
        for (int k = 0; k < 4; k++) begin
            send_op(MODE_REMOVE, QIDX_W'(k), '1, '1);
        end
        send_op(MODE_APPEND, 2'd3, 16'hFFFF, 16'hFFFF);
        send_op(MODE_APPEND, 2'd3, 16'h0000, 16'h0000);
        wait_drained();
    endtask

    task automatic test_fifo_order();
        send_op(MODE_APPEND, 2'd0, 16'h0000, 16'h0000);
        send_op(MODE_APPEND, 2'd0, 16'hFFFF, 16'hFFFF);
        send_op(MODE_APPEND, 2'd1, 16'h5555, 16'hAAAA);
        send_op(MODE_APPEND, 2'd0, 16'hAAAA, 16'h5555);
        send_op(MODE_APPEND, 2'd2, 16'h0001, 16'h8000);
        send_op(MODE_REMOVE, 2'd0, '0, '0);
        send_op(MODE_REMOVE, 2'd0, '0, '0);
        send_op(MODE_REMOVE, 2'd0, '0, '0);
        send_op(MODE_REMOVE, 2'd0, '0, '0);
        send_op(MODE_REMOVE, 2'd1, '0, '0);
        send_op(MODE_REMOVE, 2'd2, '0, '0);
        send_op(MODE_APPEND, 2'd2, 16'h8000, 16'h0001);
        send_op(MODE_APPEND, 2'd2, 16'h1234, 16'hFEDC);
        send_op(MODE_REMOVE, 2'd2, '0, '0);
        send_op(MODE_APPEND, 2'd2, 16'h7FFF, 16'hFFFE);
        send_op(MODE_REMOVE, 2'd2, '0, '0);
        send_op(MODE_REMOVE, 2'd2, '0, '0);
        wait_drained();
    endtask

    task automatic test_pool_full();
        // stall the result side so the block backs up on its input
        sink_hold = LONG_HOLD;
        for (int k = 0; k < POOL_DEPTH + 4; k++) begin
            send_op(MODE_APPEND, QIDX_W'($urandom_range(0, NUM_QUEUES - 1)),
                    DATA_W'($urandom), DATA_W'($urandom));
        end
        send_op(MODE_APPEND, 2'd3, DATA_W'($urandom), DATA_W'($urandom));
        send_op(MODE_REMOVE, 2'd1, '0, '0);
        send_op(MODE_APPEND, 2'd1, DATA_W'($urandom), DATA_W'($urandom));
        send_op(MODE_APPEND, 2'd0, DATA_W'($urandom), DATA_W'($urandom));
        wait_drained();
        for (int q = 0; q < NUM_QUEUES; q++) begin
            while (q_live[q]) send_op(MODE_REMOVE, QIDX_W'(q), '0, '0);
            send_op(MODE_REMOVE, QIDX_W'(q), '0, '0);
        end
        wait_drained();
    endtask

    task automatic test_random_mix();
        int fill_bias;
        logic mode;
        logic [QIDX_W-1:0] qi;
        logic [DATA_W-1:0] cls;
        logic [DATA_W-1:0] grd;
        fill_bias = 50;
        for (int n = 0; n < RANDOM_OPS; n++) begin
            if (n % 60 == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                fill_bias = $urandom_range(0, 1) ? 75 : 30;
            end
            mode = ($urandom_range(0, 99) < fill_bias) ? MODE_APPEND : MODE_REMOVE;
            qi = ($urandom_range(0, 15) == 0) ? 2'd3
                                              : QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
            case ($urandom_range(0, 7))
                0: begin
                    cls = '0;
                    grd = '1;
                end
                1: begin
                    cls = '1;
                    grd = '0;
                end
                default: begin
                    cls = DATA_W'($urandom);
                    grd = DATA_W'($urandom);
                end
            endcase
            send_op(mode, qi, cls, grd);
        end
        calm = 1'b0;
        wait_drained();
    endtask

    initial begin
        clear_shadow();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_empty_and_range();
        test_fifo_order();
        test_pool_full();
        test_random_mix();
        repeat (SETTLE) @(posedge aclk);
        if (replies_due.size() != 0) err_count++;
        if (err_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
